// ===== rtl/ipbm_pkg.sv =====
// ----------------------------------------------------------------------------
// ipbm_pkg
// Types and constants shared by the passive bus monitor modules.
// ----------------------------------------------------------------------------
package ipbm_pkg;

  typedef enum logic [3:0] {
    PH_SYNC       = 4'd0,
    PH_IDLE       = 4'd1,
    PH_START_LOW  = 4'd2,
    PH_BIT_HIGH   = 4'd3,
    PH_BIT_LOW    = 4'd4,
    PH_NACK_LOW   = 4'd5,
    PH_ACK_LOW    = 4'd6,
    PH_FIRST_HIGH = 4'd7,
    PH_FIRST_ONE  = 4'd8,
    PH_FIRST_ZERO = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_RESTART = 2'd1,
    EV_BYTE    = 2'd2,
    EV_STOP    = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic       is_address;
    logic       acked;
    logic [7:0] byte_value;
    ev_kind_t   kind;
  } event_t;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ===== rtl/ipbm_front.sv =====
// ----------------------------------------------------------------------------
// ipbm_front
// Follows the bus phase one line sample per cycle while the queue has space and classifies events.
// ----------------------------------------------------------------------------
module ipbm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             smp_valid,
  output logic             smp_ready,
  input  logic             scl,
  input  logic             sda,
  input  logic             enable,
  input  logic             q_space,
  output logic             ev_valid,
  output ipbm_pkg::event_t ev
);

  ipbm_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       bit_count_r, bit_count_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             last_sda_r;
  logic             addr_r, addr_nxt;
  logic             fire;
  logic             high_both;
  logic             start_cond;

  assign smp_ready  = q_space;
  assign fire       = smp_valid & q_space;
  assign high_both  = scl & sda;
  assign start_cond = scl & ~sda;

  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    addr_nxt      = addr_r;
    unique case (phase_r)
      ipbm_pkg::PH_IDLE: begin
        if (start_cond) begin
          if (enable) begin
            addr_nxt      = 1'b1;
            bit_count_nxt = '0;
            shift_nxt     = '0;
            phase_nxt     = ipbm_pkg::PH_START_LOW;
          end else begin
            phase_nxt = ipbm_pkg::PH_SYNC;
          end
        end else if (!high_both) begin
          phase_nxt = ipbm_pkg::PH_SYNC;
        end
      end
      ipbm_pkg::PH_START_LOW, ipbm_pkg::PH_BIT_LOW: begin
        if (!scl) begin
          phase_nxt = ipbm_pkg::PH_BIT_HIGH;
        end
      end
      ipbm_pkg::PH_BIT_HIGH: begin
        if (scl) begin
          if (bit_count_r < ipbm_pkg::BITS_PER_BYTE) begin
            shift_nxt     = {shift_r[6:0], sda};
            bit_count_nxt = bit_count_r + 4'd1;
            phase_nxt     = ipbm_pkg::PH_BIT_LOW;
          end else if (addr_r && sda) begin
            phase_nxt = ipbm_pkg::PH_NACK_LOW;
          end else begin
            phase_nxt = ipbm_pkg::PH_ACK_LOW;
          end
        end
      end
      ipbm_pkg::PH_NACK_LOW: begin
        if (!scl) begin
          addr_nxt  = 1'b0;
          phase_nxt = ipbm_pkg::PH_SYNC;
        end
      end
      ipbm_pkg::PH_ACK_LOW: begin
        if (!scl) begin
          bit_count_nxt = '0;
          shift_nxt     = '0;
          addr_nxt      = 1'b0;
          phase_nxt     = addr_r ? ipbm_pkg::PH_BIT_HIGH : ipbm_pkg::PH_FIRST_HIGH;
        end
      end
      ipbm_pkg::PH_FIRST_HIGH: begin
        if (scl) begin
          shift_nxt     = {7'd0, last_sda_r};
          bit_count_nxt = 4'd1;
          if (last_sda_r) begin
            if (sda) begin
              phase_nxt = ipbm_pkg::PH_FIRST_ONE;
            end else if (enable) begin
              addr_nxt      = 1'b1;
              bit_count_nxt = '0;
              shift_nxt     = '0;
              phase_nxt     = ipbm_pkg::PH_START_LOW;
            end else begin
              phase_nxt = ipbm_pkg::PH_SYNC;
            end
          end else begin
            phase_nxt = sda ? ipbm_pkg::PH_SYNC : ipbm_pkg::PH_FIRST_ZERO;
          end
        end
      end
      ipbm_pkg::PH_FIRST_ONE: begin
        if (!scl) begin
          phase_nxt = ipbm_pkg::PH_BIT_HIGH;
        end else if (!sda) begin
          if (enable) begin
            addr_nxt      = 1'b1;
            bit_count_nxt = '0;
            shift_nxt     = '0;
            phase_nxt     = ipbm_pkg::PH_START_LOW;
          end else begin
            phase_nxt = ipbm_pkg::PH_SYNC;
          end
        end
      end
      ipbm_pkg::PH_FIRST_ZERO: begin
        if (!scl) begin
          phase_nxt = ipbm_pkg::PH_BIT_HIGH;
        end else if (sda) begin
          phase_nxt = ipbm_pkg::PH_SYNC;
        end
      end
      default: begin
        phase_nxt = high_both ? ipbm_pkg::PH_IDLE : ipbm_pkg::PH_SYNC;
      end
    endcase
  end

  always_comb begin
    ev_valid      = 1'b0;
    ev.kind       = ipbm_pkg::EV_START;
    ev.byte_value = '0;
    ev.acked      = 1'b0;
    ev.is_address = 1'b0;
    unique case (phase_r)
      ipbm_pkg::PH_IDLE: begin
        ev_valid = start_cond & enable;
      end
      ipbm_pkg::PH_BIT_HIGH: begin
        if (scl && !(bit_count_r < ipbm_pkg::BITS_PER_BYTE)) begin
          ev_valid      = 1'b1;
          ev.kind       = ipbm_pkg::EV_BYTE;
          ev.byte_value = shift_r;
          ev.acked      = ~sda;
          ev.is_address = addr_r;
        end
      end
      ipbm_pkg::PH_FIRST_HIGH: begin
        if (scl) begin
          if (last_sda_r) begin
            ev_valid = ~sda & enable;
            ev.kind  = ipbm_pkg::EV_RESTART;
          end else begin
            ev_valid = sda;
            ev.kind  = ipbm_pkg::EV_STOP;
          end
        end
      end
      ipbm_pkg::PH_FIRST_ONE: begin
        ev_valid = start_cond & enable;
        ev.kind  = ipbm_pkg::EV_RESTART;
      end
      ipbm_pkg::PH_FIRST_ZERO: begin
        ev_valid = high_both;
        ev.kind  = ipbm_pkg::EV_STOP;
      end
      default: begin
        ev_valid = 1'b0;
      end
    endcase
    ev_valid = ev_valid & fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ipbm_pkg::PH_SYNC;
      bit_count_r <= '0;
      shift_r     <= '0;
      last_sda_r  <= 1'b1;
      addr_r      <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      last_sda_r  <= sda;
      addr_r      <= addr_nxt;
    end
  end

endmodule

// ===== rtl/ipbm_queue.sv =====
// ----------------------------------------------------------------------------
// ipbm_queue
// Short first-in first-out queue of events between the front and back parts.
// ----------------------------------------------------------------------------
module ipbm_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ipbm_pkg::event_t push_data,
  output logic             space,
  input  logic             pop,
  output logic             head_valid,
  output ipbm_pkg::event_t head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  ipbm_pkg::event_t        store_r [DEPTH];
  logic [PW-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    do_pop;

  assign space      = (count_r != FULL);
  assign head_valid = (count_r != '0);
  assign head_data  = store_r[rd_ptr_r];
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/ipbm_back.sv =====
// ----------------------------------------------------------------------------
// ipbm_back
// Output register that presents queued events on the result stream.
// ----------------------------------------------------------------------------
module ipbm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  ipbm_pkg::event_t head_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output ipbm_pkg::event_t out_data
);

  logic             valid_r, valid_nxt;
  ipbm_pkg::event_t data_r;

  assign pop       = head_valid & (~valid_r | out_ready);
  assign valid_nxt = pop | (valid_r & ~out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head_data;
    end
  end

endmodule

// ===== rtl/i2c_passive_bus_monitor.sv =====
// ----------------------------------------------------------------------------
// i2c_passive_bus_monitor
// Passive decoder of a two-wire serial bus from sampled line levels.
// ----------------------------------------------------------------------------
// The monitor takes one sample of both bus lines per cycle while in_tready is
// high and reports start, repeated start, byte and stop events. An event passes
// through the queue and then the output register before it appears on the
// result stream. Events wait in a queue of QUEUE_DEPTH entries behind the
// output register; in_tready falls only when that queue is full, so samples
// are taken one per cycle as long as the result side keeps up.
module i2c_passive_bus_monitor #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] scl_level, [1] sda_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] byte_value, [8] acked, [9] is_address
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // [0] monitor_enable
);

  logic             enable_r;
  logic             q_space;
  logic             ev_valid;
  ipbm_pkg::event_t ev;
  logic             head_valid;
  ipbm_pkg::event_t head_data;
  logic             pop;
  ipbm_pkg::event_t out_ev;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_valid) begin
      enable_r <= cfg_data;
    end
  end

  ipbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (in_tvalid),
    .smp_ready (in_tready),
    .scl       (in_tdata[0]),
    .sda       (in_tdata[1]),
    .enable    (enable_r),
    .q_space   (q_space),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  ipbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ev_valid),
    .push_data  (ev),
    .space      (q_space),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  ipbm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_ev)
  );

  assign out_tdata = {6'd0, out_ev.is_address, out_ev.acked, out_ev.byte_value};
  assign out_tuser = out_ev.kind;

endmodule

// ===== rtl/ipbm_checker.sv =====
// ----------------------------------------------------------------------------
// ipbm_checker
// Port-level checks on the result stream of the passive bus monitor.
// ----------------------------------------------------------------------------
module ipbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result stream valid directly after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result transaction changed");

  a_condition_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ipbm_pkg::EV_BYTE) |-> out_tdata == 16'd0)
    else $error("bus condition event carries byte data");

  a_padding_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:10] == 6'd0)
    else $error("padding bits of result data are not zero");

endmodule

bind i2c_passive_bus_monitor ipbm_checker u_ipbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
